// File: sv/bll_pkg.sv
// Shared types, codes and character classes for the line lexer.
package bll_pkg;

    typedef enum logic [3:0] {
        M_START, M_BLANK, M_LIT, M_LITQ, M_AMP, M_BIN, M_OCT, M_HEX,
        M_OP, M_IDENT, M_INT, M_FRAC, M_EXP0, M_EXPS, M_EXPD, M_TAIL
    } t_mode;

    localparam logic [2:0] K_EOL   = 3'd0;
    localparam logic [2:0] K_BLANK = 3'd1;
    localparam logic [2:0] K_LIT   = 3'd2;
    localparam logic [2:0] K_PLAIN = 3'd3;
    localparam logic [2:0] K_INT   = 3'd4;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_EQ   = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  len;
        logic [30:0] val;
    } t_tok;

    typedef struct packed {
        t_tok [2:0] tok;
        logic [1:0] cnt;
    } t_bundle;

    function automatic logic is_sp(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dg(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_al(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_id(input logic [7:0] c);
        return is_al(c) || is_dg(c) || c == "_";
    endfunction

    function automatic logic is_xd(input logic [7:0] c);
        return is_dg(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

endpackage

// File: sv/bll_if.sv
// Request channel interfaces for characters in and tokens out.
interface bll_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_end;
    modport source (output valid, char_in, line_end, input ready);
    modport sink (input valid, char_in, line_end, output ready);
endinterface

interface bll_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [7:0]  token_length;
    logic [30:0] int_value;
    logic        last_result;
    modport source (output valid, token_kind, token_length, int_value, last_result,
                    input ready);
    modport sink (input valid, token_kind, token_length, int_value, last_result,
                  output ready);
endinterface

// File: sv/bll_front.sv
// Lexer front: classifies each character, updates token state, pushes result bundles.
module bll_front import bll_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int INT_BITS      = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bll_in_if.sink      i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_bundle     o_bundle
);
    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LMAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] LONE = LEN_W'(1);
    localparam logic [INT_BITS+3:0] VMAX = {4'b0, {INT_BITS{1'b1}}};

    t_mode               r_mode, n_mode;
    logic [LEN_W-1:0]    r_cnt, n_cnt, r_sp, n_sp;
    logic [1:0]          r_op, n_op;
    logic [INT_BITS-1:0] r_acc, n_acc;
    logic                r_ovf, n_ovf, r_ic, n_ic;

    t_tok [2:0]          res;
    logic [1:0]          rn;
    logic                do_end, eol, acc_in, partner;
    logic [7:0]          c;
    logic [INT_BITS+3:0] wide;

    function automatic logic [LEN_W-1:0] sat1(input logic [LEN_W-1:0] a);
        return (a == LMAX) ? LMAX : a + LONE;
    endfunction

    function automatic logic [LEN_W-1:0] sat2(input logic [LEN_W-1:0] a);
        logic [LEN_W:0] s;
        s = {1'b0, a} + (LEN_W+1)'(2);
        return (s > {1'b0, LMAX}) ? LMAX : s[LEN_W-1:0];
    endfunction

    function automatic t_tok mk(input logic [2:0] k, input logic [LEN_W-1:0] l,
                                input logic [INT_BITS-1:0] v);
        logic [31:0] l32;
        logic [63:0] v64;
        t_tok t;
        l32 = 32'(l);
        v64 = 64'(v);
        t.kind = k;
        t.len = l32[7:0];
        t.val = v64[30:0];
        return t;
    endfunction

    assign c = i_in.char_in;
    assign eol = i_in.line_end || (c == 8'd0);
    assign i_in.ready = !i_full;
    assign acc_in = i_in.valid && !i_full;

    always_comb begin
        case (r_op)
            OP_EQ:   partner = (c == ">") || (c == "<");
            OP_LT:   partner = (c == "=") || (c == ">");
            OP_GT:   partner = (c == "=") || (c == "<");
            default: partner = 1'b0;
        endcase
    end

    assign wide = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                + (INT_BITS+4)'(c - "0");

    always_comb begin
        n_mode = r_mode; n_cnt = r_cnt; n_sp = r_sp; n_op = r_op;
        n_acc = r_acc; n_ovf = r_ovf; n_ic = r_ic;
        res = '0;
        rn = 2'd0;
        do_end = 1'b0;
        if (!eol) begin
            case (r_mode)
                M_START: do_end = 1'b1;
                M_BLANK: if (is_sp(c)) n_cnt = sat1(r_cnt); else do_end = 1'b1;
                M_LIT: begin
                    n_cnt = sat1(r_cnt);
                    if (c == "\"") n_mode = M_LITQ;
                end
                M_LITQ: begin
                    if (c == "\"") begin
                        n_cnt = sat1(r_cnt);
                        n_mode = M_LIT;
                    end else do_end = 1'b1;
                end
                M_AMP: begin
                    n_cnt = sat1(r_cnt);
                    if (c == "x" || c == "X") n_mode = M_BIN;
                    else if (c == "o" || c == "O") n_mode = M_OCT;
                    else if (c == "h" || c == "H" || is_xd(c)) n_mode = M_HEX;
                    else begin
                        n_cnt = r_cnt;
                        do_end = 1'b1;
                    end
                end
                M_BIN: if (c == "0" || c == "1") n_cnt = sat1(r_cnt); else do_end = 1'b1;
                M_OCT: if (c >= "0" && c <= "7") n_cnt = sat1(r_cnt); else do_end = 1'b1;
                M_HEX: if (is_xd(c)) n_cnt = sat1(r_cnt); else do_end = 1'b1;
                M_OP: begin
                    if (c == " ") begin
                        n_sp = sat1(r_sp);
                    end else if (partner) begin
                        res[rn] = mk(K_PLAIN, sat2(r_sp), '0);
                        rn = rn + 2'd1;
                        n_mode = M_START; n_cnt = '0; n_sp = '0; n_op = OP_NONE;
                        n_acc = '0; n_ovf = 1'b0; n_ic = 1'b1;
                    end else if (r_sp != '0 && is_sp(c)) begin
                        res[rn] = mk(K_PLAIN, LONE, '0);
                        rn = rn + 2'd1;
                        n_mode = M_BLANK; n_cnt = sat1(r_sp); n_sp = '0; n_op = OP_NONE;
                        n_acc = '0; n_ovf = 1'b0; n_ic = 1'b1;
                    end else do_end = 1'b1;
                end
                M_IDENT: begin
                    if (is_id(c)) begin
                        n_cnt = sat1(r_cnt);
                    end else if (c == "$") begin
                        res[rn] = mk(K_PLAIN, sat1(r_cnt), '0);
                        rn = rn + 2'd1;
                        n_mode = M_START; n_cnt = '0; n_sp = '0; n_op = OP_NONE;
                        n_acc = '0; n_ovf = 1'b0; n_ic = 1'b1;
                    end else do_end = 1'b1;
                end
                M_INT: begin
                    n_cnt = sat1(r_cnt);
                    if (is_dg(c)) begin
                        if (!r_ovf) begin
                            if (wide > VMAX) n_ovf = 1'b1;
                            else n_acc = wide[INT_BITS-1:0];
                        end
                    end else if (c == ".") begin
                        n_mode = M_FRAC; n_ic = 1'b0;
                    end else if (c == "e" || c == "E") begin
                        n_mode = M_EXP0; n_ic = 1'b0;
                    end else if (is_id(c)) begin
                        n_mode = M_TAIL; n_ic = 1'b0;
                    end else begin
                        n_cnt = r_cnt;
                        do_end = 1'b1;
                    end
                end
                M_FRAC, M_EXPD: begin
                    n_cnt = sat1(r_cnt);
                    if (r_mode == M_FRAC && (c == "e" || c == "E")) n_mode = M_EXP0;
                    else if (is_dg(c)) n_mode = r_mode;
                    else if (is_id(c)) n_mode = M_TAIL;
                    else begin
                        n_cnt = r_cnt;
                        do_end = 1'b1;
                    end
                end
                M_EXP0, M_EXPS: begin
                    n_cnt = sat1(r_cnt);
                    if (is_dg(c)) n_mode = M_EXPD;
                    else if (r_mode == M_EXP0 && (c == "+" || c == "-")) n_mode = M_EXPS;
                    else if (is_id(c)) n_mode = M_TAIL;
                    else begin
                        n_cnt = r_cnt;
                        do_end = 1'b1;
                    end
                end
                default: if (is_id(c)) n_cnt = sat1(r_cnt); else do_end = 1'b1;
            endcase
        end

        if (eol || do_end) begin
            case (r_mode)
                M_START: ;
                M_BLANK: begin
                    res[rn] = mk(K_BLANK, r_cnt, '0);
                    rn = rn + 2'd1;
                end
                M_LIT, M_LITQ: begin
                    res[rn] = mk(K_LIT, r_cnt, '0);
                    rn = rn + 2'd1;
                end
                M_OP: begin
                    res[rn] = mk(K_PLAIN, LONE, '0);
                    rn = rn + 2'd1;
                    if (r_sp != '0) begin
                        res[rn] = mk(K_BLANK, r_sp, '0);
                        rn = rn + 2'd1;
                    end
                end
                M_INT: begin
                    if (r_ic && !r_ovf) res[rn] = mk(K_INT, r_cnt, r_acc);
                    else res[rn] = mk(K_PLAIN, r_cnt, '0);
                    rn = rn + 2'd1;
                end
                default: begin
                    res[rn] = mk(K_PLAIN, r_cnt, '0);
                    rn = rn + 2'd1;
                end
            endcase
            n_mode = M_START; n_cnt = '0; n_sp = '0; n_op = OP_NONE;
            n_acc = '0; n_ovf = 1'b0; n_ic = 1'b1;
            if (eol) begin
                res[rn] = mk(K_EOL, '0, '0);
                rn = rn + 2'd1;
            end else begin
                n_cnt = LONE;
                if (is_sp(c)) n_mode = M_BLANK;
                else if (c == "\"") n_mode = M_LIT;
                else if (c == "&") n_mode = M_AMP;
                else if (c == "=" || c == "<" || c == ">") begin
                    n_mode = M_OP;
                    n_op = (c == "=") ? OP_EQ : (c == "<") ? OP_LT : OP_GT;
                end else if (is_al(c)) n_mode = M_IDENT;
                else if (is_dg(c)) begin
                    n_mode = M_INT;
                    n_acc = INT_BITS'(c - "0");
                end else if (c == ".") begin
                    n_mode = M_FRAC;
                    n_ic = 1'b0;
                end else begin
                    res[rn] = mk(K_PLAIN, LONE, '0);
                    rn = rn + 2'd1;
                    n_cnt = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_cnt <= '0;
            r_sp <= '0;
            r_op <= OP_NONE;
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_ic <= 1'b1;
        end else if (acc_in) begin
            r_mode <= n_mode;
            r_cnt <= n_cnt;
            r_sp <= n_sp;
            r_op <= n_op;
            r_acc <= n_acc;
            r_ovf <= n_ovf;
            r_ic <= n_ic;
        end
    end

    assign o_push = acc_in && (rn != 2'd0);
    assign o_bundle.tok = res;
    assign o_bundle.cnt = rn;

    a_eol_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && eol) |=> (r_mode == M_START && r_cnt == '0))
        else $error("lexer not restarted after end of line");
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && eol) |-> (o_push && o_bundle.tok[rn - 2'd1].kind == K_EOL))
        else $error("end token missing");
    a_op_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_OP) |-> (r_op != OP_NONE))
        else $error("comparison mode without operator");
endmodule

// File: sv/bll_back.sv
// Lexer back: bundle queue and result sequencer onto the output channel.
module bll_back import bll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_bundle     i_bundle,
    output logic        o_full,
    bll_out_if.source   o_out
);
    localparam int AW = $clog2(Q_DEPTH);
    localparam int NW = $clog2(Q_DEPTH + 1);

    t_bundle          r_q [Q_DEPTH];
    logic [AW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [NW-1:0]    r_n, n_n;
    logic [1:0]       r_idx, n_idx;
    t_bundle          head;
    t_tok             tok;
    logic             last, pop, oacc;

    assign head = r_q[r_rp];
    assign tok = head.tok[r_idx];
    assign last = (r_idx == head.cnt - 2'd1);
    assign o_full = (r_n == NW'(Q_DEPTH));
    assign oacc = o_out.valid && o_out.ready;
    assign pop = oacc && last;

    assign o_out.valid = (r_n != '0);
    assign o_out.token_kind = tok.kind;
    assign o_out.token_length = tok.len;
    assign o_out.int_value = tok.val;
    assign o_out.last_result = last;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_idx = r_idx;
        if (i_push) n_wp = (r_wp == AW'(Q_DEPTH - 1)) ? '0 : r_wp + AW'(1);
        if (pop) begin
            n_rp = (r_rp == AW'(Q_DEPTH - 1)) ? '0 : r_rp + AW'(1);
            n_idx = 2'd0;
        end else if (oacc) begin
            n_idx = r_idx + 2'd1;
        end
        n_n = r_n + NW'(i_push) - NW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n <= '0;
            r_idx <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_n <= n_n;
            r_idx <= n_idx;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || pop))
        else $error("push into full queue");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_idx < head.cnt))
        else $error("result index beyond bundle");
    a_idx_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_idx == 2'd0))
        else $error("result index not cleared after bundle");
endmodule

// File: sv/basic_line_lexer.sv
// Top level of the BASIC line lexer: front classifier, bundle queue, result sequencer.
// One character (or end-of-line mark) is taken per cycle unless the queue is full; each
// causes zero to three tokens, which leave at one per cycle while the sink is ready;
// the last is flagged by last_result. A two-entry queue of per-character result bundles
// sits between the lexer state machine and the output, so a one-token character keeps
// one item per cycle while the sink is ready; two- or three-token ones hold the input.
module basic_line_lexer import bll_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int INT_BITS      = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bll_in_if.sink      i_in,
    bll_out_if.source   o_out
);
    logic    full, push;
    t_bundle bundle;

    bll_front #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .INT_BITS(INT_BITS)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(i_in),
        .i_full(full),
        .o_push(push),
        .o_bundle(bundle)
    );

    bll_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_bundle(bundle),
        .o_full(full),
        .o_out(o_out)
    );
endmodule

// File: dv/bll_checker.sv
// Checker for the line lexer: watches both channels, predicts tokens and compares them.
module bll_checker import bll_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bll_in_if          i_in,
    bll_out_if         i_out,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 255;
    localparam longint MAXV = (64'd1 << 31) - 1;

    t_mode       mode;
    int unsigned tok_len;
    int unsigned spaces;
    logic [1:0]  op;
    longint      acc;
    bit          ovf;
    bit          int_ok;

    t_tok tok_q[$];
    bit   last_q[$];
    t_tok step_toks[$];

    function automatic int unsigned sat(int unsigned a, int unsigned b);
        return (a + b > MAX_LEN) ? MAX_LEN : a + b;
    endfunction

    function automatic bit sp_c(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic bit dg_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit al_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit id_c(logic [7:0] c);
        return al_c(c) || dg_c(c) || c == "_";
    endfunction
    function automatic bit xd_c(logic [7:0] c);
        return dg_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    task automatic push_tok(logic [2:0] k, int unsigned l, longint v);
        t_tok t;
        t.kind = k;
        t.len  = l[7:0];
        t.val  = v[30:0];
        if (step_toks.size() < 3) step_toks.push_back(t);
    endtask

    task automatic clear_tok();
        mode = M_START; tok_len = 0; spaces = 0; op = OP_NONE;
        acc = 0; ovf = 0; int_ok = 1;
    endtask

    task automatic add_dg(logic [7:0] c);
        longint d;
        d = c - "0";
        if (ovf) return;
        if (acc > MAXV / 10) begin
            ovf = 1;
            return;
        end
        acc = acc * 10;
        if (acc > MAXV - d) begin
            ovf = 1;
            return;
        end
        acc = acc + d;
    endtask

    task automatic flush_tok();
        case (mode)
            M_BLANK: push_tok(K_BLANK, tok_len, 0);
            M_LIT, M_LITQ: push_tok(K_LIT, tok_len, 0);
            M_OP: begin
                push_tok(K_PLAIN, 1, 0);
                if (spaces > 0) push_tok(K_BLANK, spaces, 0);
            end
            M_START: ;
            default: begin
                if (mode == M_INT && int_ok && !ovf) push_tok(K_INT, tok_len, acc);
                else push_tok(K_PLAIN, tok_len, 0);
            end
        endcase
        clear_tok();
    endtask

    task automatic start_tok(logic [7:0] c);
        clear_tok();
        tok_len = 1;
        if (sp_c(c)) mode = M_BLANK;
        else if (c == "\"") mode = M_LIT;
        else if (c == "&") mode = M_AMP;
        else if (c == "=" || c == "<" || c == ">") begin
            mode = M_OP;
            op = (c == "=") ? OP_EQ : (c == "<") ? OP_LT : OP_GT;
        end else if (al_c(c)) mode = M_IDENT;
        else if (dg_c(c)) begin
            mode = M_INT;
            add_dg(c);
        end else if (c == ".") begin
            mode = M_FRAC;
            int_ok = 0;
        end else begin
            push_tok(K_PLAIN, 1, 0);
            clear_tok();
        end
    endtask

    task automatic restart(logic [7:0] c);
        flush_tok();
        start_tok(c);
    endtask

    function automatic bit partner(logic [7:0] c);
        if (op == OP_EQ) return c == ">" || c == "<";
        if (op == OP_LT) return c == "=" || c == ">";
        return c == "=" || c == "<";
    endfunction

    task automatic lex_char(logic [7:0] c);
        int unsigned s;
        case (mode)
            M_START: start_tok(c);
            M_BLANK: if (sp_c(c)) tok_len = sat(tok_len, 1); else restart(c);
            M_LIT: begin
                tok_len = sat(tok_len, 1);
                if (c == "\"") mode = M_LITQ;
            end
            M_LITQ: if (c == "\"") begin
                tok_len = sat(tok_len, 1);
                mode = M_LIT;
            end else restart(c);
            M_AMP: begin
                if (c == "x" || c == "X") mode = M_BIN;
                else if (c == "o" || c == "O") mode = M_OCT;
                else if (c == "h" || c == "H" || xd_c(c)) mode = M_HEX;
                else begin
                    restart(c);
                    return;
                end
                tok_len = sat(tok_len, 1);
            end
            M_BIN: if (c == "0" || c == "1") tok_len = sat(tok_len, 1); else restart(c);
            M_OCT: if (c >= "0" && c <= "7") tok_len = sat(tok_len, 1); else restart(c);
            M_HEX: if (xd_c(c)) tok_len = sat(tok_len, 1); else restart(c);
            M_OP: begin
                if (c == " ") spaces = sat(spaces, 1);
                else if (partner(c)) begin
                    push_tok(K_PLAIN, sat(spaces, 2), 0);
                    clear_tok();
                end else if (spaces > 0 && sp_c(c)) begin
                    s = sat(spaces, 1);
                    push_tok(K_PLAIN, 1, 0);
                    clear_tok();
                    mode = M_BLANK;
                    tok_len = s;
                end else restart(c);
            end
            M_IDENT: begin
                if (id_c(c)) tok_len = sat(tok_len, 1);
                else if (c == "$") begin
                    push_tok(K_PLAIN, sat(tok_len, 1), 0);
                    clear_tok();
                end else restart(c);
            end
            M_INT: begin
                if (dg_c(c)) add_dg(c);
                else if (c == ".") begin
                    mode = M_FRAC;
                    int_ok = 0;
                end else if (c == "e" || c == "E") begin
                    mode = M_EXP0;
                    int_ok = 0;
                end else if (id_c(c)) begin
                    mode = M_TAIL;
                    int_ok = 0;
                end else begin
                    restart(c);
                    return;
                end
                tok_len = sat(tok_len, 1);
            end
            M_FRAC, M_EXPD: begin
                if (mode == M_FRAC && (c == "e" || c == "E")) mode = M_EXP0;
                else if (dg_c(c)) ;
                else if (id_c(c)) mode = M_TAIL;
                else begin
                    restart(c);
                    return;
                end
                tok_len = sat(tok_len, 1);
            end
            M_EXP0, M_EXPS: begin
                if (dg_c(c)) mode = M_EXPD;
                else if (mode == M_EXP0 && (c == "+" || c == "-")) mode = M_EXPS;
                else if (id_c(c)) mode = M_TAIL;
                else begin
                    restart(c);
                    return;
                end
                tok_len = sat(tok_len, 1);
            end
            default: if (id_c(c)) tok_len = sat(tok_len, 1); else restart(c);
        endcase
    endtask

    task automatic predict_tokens(logic [7:0] c, logic eol);
        step_toks.delete();
        if (eol || c == 8'd0) begin
            flush_tok();
            push_tok(K_EOL, 0, 0);
            clear_tok();
        end else begin
            lex_char(c);
        end
        foreach (step_toks[i]) begin
            tok_q.push_back(step_toks[i]);
            last_q.push_back(i == step_toks.size() - 1);
        end
    endtask

    always @(posedge i_clk) begin
        t_tok exp_t;
        bit   exp_l;
        if (!i_rst_n) begin
            clear_tok();
            tok_q.delete();
            last_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (tok_q.size() == 0) begin
                    $display("%0t: unexpected token kind=%0d len=%0d val=%0d", $time,
                             i_out.token_kind, i_out.token_length, i_out.int_value);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_t = tok_q.pop_front();
                    exp_l = last_q.pop_front();
                    if (i_out.token_kind !== exp_t.kind || i_out.token_length !== exp_t.len
                        || i_out.int_value !== exp_t.val || i_out.last_result !== exp_l) begin
                        $display("%0t: mismatch exp kind=%0d len=%0d val=%0d last=%0d",
                                 $time, exp_t.kind, exp_t.len, exp_t.val, exp_l);
                        $display("%0t:          act kind=%0d len=%0d val=%0d last=%0d",
                                 $time, i_out.token_kind, i_out.token_length,
                                 i_out.int_value, i_out.last_result);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) predict_tokens(i_in.char_in, i_in.line_end);
            o_pending <= tok_q.size();
        end
    end
endmodule

// File: dv/tb_basic_line_lexer.sv
// Top of the line lexer testbench: clock, reset, character stimulus and verdict.
module tb_basic_line_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors;
    int   pending;
    byte unsigned line_q[$];
    bit   eol_q[$];

    bll_in_if  in_if();
    bll_out_if out_if();

    basic_line_lexer u_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if), .o_out(out_if));
    bll_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if), .i_out(out_if),
                       .o_errors(errors), .o_pending(pending));

    always #10 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    // sink side stall pattern
    initial begin
        int gap;
        out_if.ready = 0;
        @(posedge i_clk);
        while (1) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 5) == 0) gap = 0;
            if (gap > 0) begin
                out_if.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1;
            @(posedge i_clk);
            while (!(out_if.valid && out_if.ready)) @(posedge i_clk);
        end
    end

    task automatic add_str(string s);
        foreach (s[i]) begin
            line_q.push_back(s[i]);
            eol_q.push_back(0);
        end
    endtask

    task automatic add_eol(bit zero_byte);
        line_q.push_back(zero_byte ? 8'd0 : 8'($urandom_range(0, 255)));
        eol_q.push_back(1);
    endtask

    task automatic send_request(byte unsigned c, bit eol, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1;
        in_if.char_in  <= c;
        in_if.line_end <= eol;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    function automatic string rand_frag();
        string pool[$];
        string s;
        pool = '{"\"ab\"\"c\"", "&X101", "&o777", "&HfF", "&1a", "&", "= <", "< >",
                 ">  \t", "=  x", "ab_1$", "Ab9", "12345", "2147483647", "2147483648",
                 "99999999999", "1.5e+3", ".25", "3E-", "7e", "12ab", "1.2x",
                 "   ", "\t\n", "+", "(", ":", "\"open", "0", "x$y"};
        s = pool[$urandom_range(0, pool.size() - 1)];
        return s;
    endfunction

    initial begin
        int n;
        string s;
        in_if.valid = 0;
        in_if.char_in = 0;
        in_if.line_end = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        add_str("A$=\"x\"\"y\" : IF B<  >2147483648 THEN ");
        add_eol(0);
        add_str("&x1=>7.e+5 ");
        add_eol(1);
        line_q.push_back(8'hFF);
        eol_q.push_back(0);
        line_q.push_back(8'h80);
        eol_q.push_back(0);
        line_q.push_back(8'h01);
        eol_q.push_back(0);
        add_str("=  \t9");
        add_eol(0);
        while (line_q.size() > 0) send_request(line_q.pop_front(), eol_q.pop_front(), 0);

        // a long identifier or a long blank run to reach length saturation
        s = ($urandom_range(0, 1) == 0) ? "Q" : " ";
        repeat (258) add_str(s);
        add_eol(0);
        while (line_q.size() > 0) send_request(line_q.pop_front(), eol_q.pop_front(), 1);

        n = 0;
        while (n < 160) begin
            if ($urandom_range(0, 9) == 0) begin
                line_q.push_back(8'($urandom_range(1, 255)));
                eol_q.push_back(0);
            end else begin
                add_str(rand_frag());
            end
            if ($urandom_range(0, 7) == 0) add_eol(1'($urandom_range(0, 1)));
            while (line_q.size() > 0) begin
                send_request(line_q.pop_front(), eol_q.pop_front(),
                             $urandom_range(0, 2) == 0);
                n++;
            end
        end
        send_request(8'd0, 1, 0);
        in_if.valid <= 0;
        @(posedge i_clk);

        while (pending > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
